[rtl/core/mkd_pkg.sv]
// mkd_pkg: shared constants, types and entry layout for the keypad debouncer.
// Depends on nothing; imported by mkd_row_update and matrix_keypad_debouncer_core.
package mkd_pkg;

  localparam int HISTORY_LEN = 16;
  localparam int ROWS        = 4;
  localparam int COLS        = 4;
  localparam int IN_COLS     = 4;
  localparam int ROW_W       = 2;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [IN_COLS-1:0] column_levels;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_echo;
    logic [IN_COLS-1:0] stable_levels;
    logic [IN_COLS-1:0] press_mask;
    logic [IN_COLS-1:0] release_mask;
  } rsp_t;

  // one memory word holds a whole row
  typedef struct packed {
    logic [COLS-1:0][HISTORY_LEN-1:0] hist;
    logic [COLS-1:0]                  stable;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{hist: '1, stable: '1};

  typedef struct packed {
    req_t   req;
    entry_t cur;
  } upd_in_t;

  typedef struct packed {
    entry_t entry;
    rsp_t   rsp;
  } upd_out_t;

endpackage

[rtl/core/mkd_row_update.sv]
// mkd_row_update: per-row history shift, stable-state decision and edge masks.
// Combinational; depends on mkd_pkg.
module mkd_row_update (
  input  mkd_pkg::upd_in_t  upd_in,
  output mkd_pkg::upd_out_t upd_out
);
  import mkd_pkg::*;

  always_comb begin
    logic [HISTORY_LEN-1:0] h;
    logic                   smp;
    logic                   nst;
    upd_out.entry             = upd_in.cur;
    upd_out.rsp.row_echo      = upd_in.req.row_index;
    upd_out.rsp.stable_levels = '1;
    upd_out.rsp.press_mask    = '0;
    upd_out.rsp.release_mask  = '0;
    for (int c = 0; c < COLS; c++) begin
      smp = 1'b1;
      if (c < IN_COLS) begin
        smp = upd_in.req.column_levels[c];
      end
      h = {upd_in.cur.hist[c][HISTORY_LEN-2:0], smp};
      nst = upd_in.cur.stable[c];
      if (h == '0) begin
        nst = 1'b0;
      end else if (h == '1) begin
        nst = 1'b1;
      end
      upd_out.entry.hist[c]   = h;
      upd_out.entry.stable[c] = nst;
      if (c < IN_COLS) begin
        upd_out.rsp.stable_levels[c] = nst;
        upd_out.rsp.press_mask[c]    = upd_in.cur.stable[c] & ~nst;
        upd_out.rsp.release_mask[c]  = ~upd_in.cur.stable[c] & nst;
      end
    end
  end

endmodule

[rtl/core/matrix_keypad_debouncer_core.sv]
// matrix_keypad_debouncer_core: 4x4 keypad debouncer, row state held in a
// synchronous row memory; depends on mkd_pkg and mkd_row_update.
// Accepted requests go through stage one into the registered response.
// Throughput: one transaction per cycle unless rsp_stall holds; row memory
// read at accept, written as stage one advances, same-row back-to-back
// handled by forwarding. Reset: per-row valid bits cleared at once; an
// unwritten row reads as all released. No clearing pass.
module matrix_keypad_debouncer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mkd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mkd_pkg::rsp_t rsp
);
  import mkd_pkg::*;

  entry_t          mem [ROWS];
  logic [ROWS-1:0] row_valid;

  entry_t   rd_data;
  logic     rd_valid;
  logic     fwd_hit;
  entry_t   fwd_data;
  logic     s1_valid;
  req_t     s1_req;
  logic     s1_adv;
  logic     req_acc;
  upd_in_t  upd_in;
  upd_out_t upd_out;

  assign s1_adv    = s1_valid && !(rsp_valid && rsp_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign req_acc   = req_valid && !req_stall;

  always_comb begin
    upd_in.req = s1_req;
    if (fwd_hit) begin
      upd_in.cur = fwd_data;
    end else if (rd_valid) begin
      upd_in.cur = rd_data;
    end else begin
      upd_in.cur = ENTRY_RESET;
    end
  end

  mkd_row_update u_upd (
    .upd_in  (upd_in),
    .upd_out (upd_out)
  );

  always_ff @(posedge clk) begin
    if (req_acc) begin
      rd_data  <= mem[req.row_index];
      rd_valid <= row_valid[req.row_index];
      fwd_hit  <= s1_adv && (s1_req.row_index == req.row_index);
      fwd_data <= upd_out.entry;
      s1_req   <= req;
    end
    if (s1_adv) begin
      mem[s1_req.row_index] <= upd_out.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        row_valid[s1_req.row_index] <= 1'b1;
      end
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= upd_out.rsp;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled with free stage");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> s1_valid)
    else $error("accepted transaction lost before stage one");

  a_mask_disjoint: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.press_mask & rsp.release_mask) == '0))
    else $error("key both pressed and released");

  a_press_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.press_mask & rsp.stable_levels) == '0
                   && (rsp.release_mask & ~rsp.stable_levels) == '0))
    else $error("edge mask disagrees with stable state");

endmodule
